FILE: rtl/cha_pkg.sv
package cha_pkg;

    localparam int IN_W            = 13;
    localparam int HDG_W           = 15;
    localparam int ACC_FRAC        = 24;
    localparam int VEC_FRAC        = 20;
    localparam int ANGLE_TABLE_LEN = 24;

    // vector: sample scaled by 2^20, plus growth and sign
    localparam int XW = IN_W + VEC_FRAC + 3;
    // angle accumulator, units of 2^-24 degree
    localparam int ZW = 35;

    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 6;

    localparam logic signed [ZW-1:0] DEG90  = ZW'(64'd90  << ACC_FRAC);
    localparam logic signed [ZW-1:0] DEG180 = ZW'(64'd180 << ACC_FRAC);
    localparam logic signed [ZW-1:0] DEG270 = ZW'(64'd270 << ACC_FRAC);
    localparam logic signed [ZW-1:0] DEG360 = ZW'(64'd360 << ACC_FRAC);

    typedef logic signed [XW-1:0] t_vec;
    typedef logic signed [ZW-1:0] t_ang;

    // atan(2^-i), units of 2^-24 degree, rounded to nearest
    function automatic logic [29:0] f_atan(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd754974720;
            5'd1:    v = 30'd445687602;
            5'd2:    v = 30'd235489088;
            5'd3:    v = 30'd119537938;
            5'd4:    v = 30'd60000934;
            5'd5:    v = 30'd30029717;
            5'd6:    v = 30'd15018523;
            5'd7:    v = 30'd7509720;
            5'd8:    v = 30'd3754917;
            5'd9:    v = 30'd1877466;
            5'd10:   v = 30'd938734;
            5'd11:   v = 30'd469367;
            5'd12:   v = 30'd234684;
            5'd13:   v = 30'd117342;
            5'd14:   v = 30'd58671;
            5'd15:   v = 30'd29335;
            5'd16:   v = 30'd14668;
            5'd17:   v = 30'd7334;
            5'd18:   v = 30'd3667;
            5'd19:   v = 30'd1833;
            5'd20:   v = 30'd917;
            5'd21:   v = 30'd458;
            5'd22:   v = 30'd229;
            5'd23:   v = 30'd115;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/cha_in_if.sv
interface cha_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [cha_pkg::IN_W-1:0] mag_x;
    logic signed [cha_pkg::IN_W-1:0] mag_y;

    modport source (output valid, output mag_x, output mag_y, input ready);
    modport sink   (input valid, input mag_x, input mag_y, output ready);
endinterface

FILE: rtl/cha_out_if.sv
interface cha_out_if;
    logic                      valid;
    logic                      ready;
    logic [cha_pkg::HDG_W-1:0] heading;

    modport source (output valid, output heading, input ready);
    modport sink   (input valid, input heading, output ready);
endinterface

FILE: rtl/compass_heading_atan2.sv
// channel  | dir | beat fields       | handshake
// ---------+-----+-------------------+-------------
// i_smp    | in  | mag_x, mag_y      | valid/ready
// o_hdg    | out | heading           | valid/ready
//
// One beat accepted per cycle unless o_hdg stalls; the pipeline holds an input
// stage, one register per CORDIC rotation and a rounding stage.
// i_rst_n is synchronous, active low, and clears the valid bits only.
// A stall at o_hdg freezes the whole pipeline; i_smp.ready is low only
// while a finished heading waits and o_hdg.ready is low.
module compass_heading_atan2 #(
    parameter int CORDIC_STAGES   = cha_pkg::CORDIC_STAGES_DEF,
    parameter int ANGLE_FRAC_BITS = cha_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cha_in_if.sink    i_smp,
    cha_out_if.source o_hdg
);

    localparam int NS     = (CORDIC_STAGES < cha_pkg::ANGLE_TABLE_LEN) ?
                            CORDIC_STAGES : cha_pkg::ANGLE_TABLE_LEN;
    localparam int RND_SH = cha_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [cha_pkg::ZW-1:0] RND_ADD =
        cha_pkg::ZW'(64'd1 << (RND_SH - 1));
    localparam logic signed [cha_pkg::ZW-1:0] FULL =
        cha_pkg::ZW'(64'd360 << ANGLE_FRAC_BITS);

    logic          en;
    logic          r_vld [0:NS];
    logic          r_sp  [0:NS];
    cha_pkg::t_vec r_x   [0:NS];
    cha_pkg::t_vec r_y   [0:NS];
    cha_pkg::t_ang r_z   [0:NS];

    logic                      r_out_vld;
    logic [cha_pkg::HDG_W-1:0] r_hdg;

    // advance everything unless the output is held
    assign en          = !r_out_vld || o_hdg.ready;
    assign i_smp.ready = en;

    // input stage: special cases, fold negative x, scale
    cha_pkg::t_vec n_x0;
    cha_pkg::t_vec n_y0;
    cha_pkg::t_vec sx;
    cha_pkg::t_vec sy;
    cha_pkg::t_ang n_z0;
    logic          n_sp0;

    always_comb begin
        sx    = cha_pkg::XW'(i_smp.mag_x);
        sy    = cha_pkg::XW'(i_smp.mag_y);
        n_sp0 = 1'b0;
        n_z0  = cha_pkg::DEG180;
        if (i_smp.mag_y == '0) begin
            n_sp0 = 1'b1;
            n_z0  = i_smp.mag_x[cha_pkg::IN_W-1] ? cha_pkg::DEG360 : cha_pkg::DEG180;
        end else if (i_smp.mag_x == '0) begin
            n_sp0 = 1'b1;
            n_z0  = i_smp.mag_y[cha_pkg::IN_W-1] ? cha_pkg::DEG90 : cha_pkg::DEG270;
        end else if (i_smp.mag_x[cha_pkg::IN_W-1]) begin
            // turn by 180 and carry the offset in the accumulator
            n_z0 = i_smp.mag_y[cha_pkg::IN_W-1] ? '0 : cha_pkg::DEG360;
            sx   = -sx;
            sy   = -sy;
        end
        n_x0 = sx <<< cha_pkg::VEC_FRAC;
        n_y0 = sy <<< cha_pkg::VEC_FRAC;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_smp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x[0]  <= n_x0;
            r_y[0]  <= n_y0;
            r_z[0]  <= n_z0;
            r_sp[0] <= n_sp0;
        end
    end

    // one rotation per register stage
    for (genvar k = 0; k < NS; k++) begin : g_rot
        cha_pkg::t_vec dx;
        cha_pkg::t_vec dy;
        cha_pkg::t_ang da;

        assign dx = r_y[k] >>> k;
        assign dy = r_x[k] >>> k;
        assign da = cha_pkg::ZW'(cha_pkg::f_atan(5'(k)));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sp[k+1] <= r_sp[k];
                if (r_sp[k]) begin
                    r_x[k+1] <= r_x[k];
                    r_y[k+1] <= r_y[k];
                    r_z[k+1] <= r_z[k];
                end else if (!r_y[k][cha_pkg::XW-1]) begin
                    r_x[k+1] <= r_x[k] + dx;
                    r_y[k+1] <= r_y[k] - dy;
                    r_z[k+1] <= r_z[k] + da;
                end else begin
                    r_x[k+1] <= r_x[k] - dx;
                    r_y[k+1] <= r_y[k] + dy;
                    r_z[k+1] <= r_z[k] - da;
                end
            end
        end
    end

    // rounding, clamp and output register
    cha_pkg::t_ang rnd;
    cha_pkg::t_ang n_h;

    always_comb begin
        rnd = (r_z[NS] + RND_ADD) >>> RND_SH;
        if (r_z[NS][cha_pkg::ZW-1]) begin
            n_h = '0;
        end else if (rnd > FULL) begin
            n_h = FULL;
        end else begin
            n_h = rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hdg <= n_h[cha_pkg::HDG_W-1:0];
        end
    end

    assign o_hdg.valid   = r_out_vld;
    assign o_hdg.heading = r_hdg;

endmodule

FILE: rtl/cha_checker.sv
module cha_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic signed [cha_pkg::IN_W-1:0] i_mag_x,
    input logic signed [cha_pkg::IN_W-1:0] i_mag_y,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [cha_pkg::HDG_W-1:0]       i_heading
);

    // nothing leaves the block straight after reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // with no result waiting the pipeline must take a beat
    a_take_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // a held result blocks new beats
    a_block_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("input accepted while output held");

    // held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_heading)))
        else $error("held heading changed");

    // a waiting sample beat keeps its valid and its fields
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !i_in_ready) |=>
            (i_in_valid && $stable(i_mag_x) && $stable(i_mag_y)))
        else $error("waiting sample changed");

endmodule

bind compass_heading_atan2 cha_checker u_cha_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_mag_x     (i_smp.mag_x),
    .i_mag_y     (i_smp.mag_y),
    .i_out_valid (o_hdg.valid),
    .i_out_ready (o_hdg.ready),
    .i_heading   (o_hdg.heading)
);
